### src/ecbb_pkg.sv
// Shared types and constants of the clipped box blur.
package ecbb_pkg;

  localparam int KIND_W   = 1;
  localparam int PIXEL_W  = 8;
  localparam int FWIDTH_W = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIFF_W   = 23;

  localparam logic [KIND_W-1:0]    KIND_PIXEL = 1'b0;
  localparam logic [KIND_W-1:0]    KIND_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PIXEL_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] blurred;
    logic               frame_end;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_CHECK,
    ST_SUM,
    ST_FLUSH,
    ST_DIV,
    ST_EMIT
  } back_state_t;

endpackage

### src/edge_clipped_box_blur.sv
// Top level of the edge-clipped box blur filter.
//
// Usage: push gray pixels of one frame in raster order on the input queue
// (in_push/in_full, in_kind = 0). Results pop from the output queue
// (out_empty/out_pop) in raster order, each the floor mean of the square
// window of radius RADIUS around the pixel, clipped at the frame edges.
// Results lag the input by RADIUS*width+RADIUS positions; once the frame is
// in, drain items (in_kind = 1) push out one pending result each.
// out_frame_end marks the last result of the frame; the next pixel starts a
// new frame. Write frame_width (index 0) and frame_height (index 1) on the
// cfg port only while idle; a write aborts the frame in progress.
// Timing: the engine handles one item at a time. An item that gives no
// result passes the idle, store and check states; one that gives a result
// also sums its window through the single line-store read port (one window
// tap per cycle), divides in the one-bit-per-cycle divider and is emitted.
// A short input queue takes items while the engine works, and a two-entry
// output queue holds results while the receiver stalls; a full output queue
// stalls the engine.
// Reset empties both queues, returns the frame size to 640x480 and starts a
// new frame; the line store needs no clearing.
module edge_clipped_box_blur #(
  parameter int RADIUS    = 10,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ecbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecbb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [ecbb_pkg::KIND_W-1:0]    in_kind,
  input  logic [ecbb_pkg::PIXEL_W-1:0]   in_pixel,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [ecbb_pkg::PIXEL_W-1:0]   out_blurred,
  output logic                           out_frame_end
);

  localparam int ITEM_W = $bits(ecbb_pkg::item_t);
  localparam int RES_W  = $bits(ecbb_pkg::result_t);

  ecbb_pkg::item_t   in_item, eng_item;
  ecbb_pkg::result_t eng_res, out_res;
  logic [ITEM_W-1:0] eng_item_bits;
  logic [RES_W-1:0]  out_res_bits;
  logic              front_empty, item_pop, res_push, res_full;

  assign in_item.kind  = in_kind;
  assign in_item.pixel = in_pixel;

  // front queue: hold arriving items while the engine works
  ecbb_fifo #(.DATA_W(ITEM_W), .DEPTH(4)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (item_pop),
    .empty (front_empty),
    .rdata (eng_item_bits)
  );

  assign eng_item = ecbb_pkg::item_t'(eng_item_bits);

  ecbb_back #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!front_empty),
    .item       (eng_item),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (eng_res),
    .res_full   (res_full)
  );

  // result queue: decouple the engine from a stalling receiver
  ecbb_fifo #(.DATA_W(RES_W), .DEPTH(2)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (eng_res),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_res_bits)
  );

  assign out_res       = ecbb_pkg::result_t'(out_res_bits);
  assign out_blurred   = out_res.blurred;
  assign out_frame_end = out_res.frame_end;

  // the engine never drops a result into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // the engine only takes items that are there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> !front_empty) else $error("item taken from empty queue");

  // after reset no result is shown
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty) else $error("result visible after reset");

endmodule

### src/ecbb_fifo.sv
// Small synchronous queue used on both sides of the blur engine.
module ecbb_fifo #(
  parameter int DATA_W = 9,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/ecbb_back.sv
// Blur engine: line store, window summation and iterative divider.
module ecbb_back #(
  parameter int RADIUS    = 10,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ecbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecbb_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            item_valid,
  input  ecbb_pkg::item_t                 item,
  output logic                            item_pop,
  output logic                            res_push,
  output ecbb_pkg::result_t               res,
  input  logic                            res_full
);

  localparam int RING    = 2 * RADIUS + 2;
  localparam int RING_W  = $clog2(RING);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = ecbb_pkg::HEIGHT_W;
  localparam int DIM_W   = $clog2(2 * RADIUS + 2);
  localparam int CNT_W   = 2 * DIM_W;
  localparam int SUM_W   = CNT_W + ecbb_pkg::PIXEL_W;
  localparam int ADDR_W  = $clog2(RING * MAX_WIDTH);
  localparam int DIVN_W  = $clog2(SUM_W + 1);
  localparam int LAG_W   = ecbb_pkg::DIFF_W;

  ecbb_pkg::back_state_t state_r, state_nxt;

  logic [ecbb_pkg::FWIDTH_W-1:0] width_raw_r;
  logic [HW-1:0]                 height_raw_r;
  ecbb_pkg::item_t               item_r;

  logic [HW-1:0]     in_row_r, out_row_r;
  logic [WW-1:0]     in_col_r, out_col_r;
  logic [RING_W-1:0] in_ring_r, out_ring_r;
  logic [ecbb_pkg::DIFF_W-1:0] diff_r;

  logic [RING_W-1:0] ring_r;
  logic [DIM_W-1:0]  rcnt_r;
  logic [WW-1:0]     col_r, c0_r, c1_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic              rd_v_r;
  logic [7:0]        rd_q_r;
  logic [CNT_W-1:0]  div_rem_r;
  logic [SUM_W-1:0]  div_quo_r;
  logic [DIVN_W-1:0] div_n_r;
  logic              frame_end_r;

  logic [7:0] store_mem [RING * MAX_WIDTH];

  // effective frame size, saturated into the legal range
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [LAG_W-1:0] lag;

  always_comb begin
    if (width_raw_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_raw_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_raw_r);
    end
    if (height_raw_r == '0) begin
      eff_h = HW'(1);
    end else if (int'(height_raw_r) > ecbb_pkg::MAX_HEIGHT) begin
      eff_h = HW'(ecbb_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_raw_r;
    end
    lag = LAG_W'(RADIUS) * LAG_W'(eff_w) + LAG_W'(RADIUS);
  end

  // window bounds around the next output position
  logic [HW-1:0]      rows_after;
  logic [WW-1:0]      cols_after;
  logic [DIM_W-1:0]   up_n, down_n, left_n, right_n, nrows, ncols;
  logic [RING_W:0]    start_ring;
  logic               ready, in_done, last_out;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CNT_W:0]     div_try;

  always_comb begin
    rows_after = eff_h - HW'(1) - out_row_r;
    cols_after = eff_w - WW'(1) - out_col_r;
    up_n    = (int'(out_row_r) >= RADIUS) ? DIM_W'(RADIUS) : DIM_W'(out_row_r);
    down_n  = (int'(rows_after) >= RADIUS) ? DIM_W'(RADIUS) : DIM_W'(rows_after);
    left_n  = (int'(out_col_r) >= RADIUS) ? DIM_W'(RADIUS) : DIM_W'(out_col_r);
    right_n = (int'(cols_after) >= RADIUS) ? DIM_W'(RADIUS) : DIM_W'(cols_after);
    nrows   = up_n + down_n + DIM_W'(1);
    ncols   = left_n + right_n + DIM_W'(1);
    if ((RING_W + 1)'(out_ring_r) >= (RING_W + 1)'(up_n)) begin
      start_ring = (RING_W + 1)'(out_ring_r) - (RING_W + 1)'(up_n);
    end else begin
      start_ring = (RING_W + 1)'(out_ring_r) + (RING_W + 1)'(RING) - (RING_W + 1)'(up_n);
    end
    in_done  = (in_row_r == eff_h);
    ready    = (out_row_r < eff_h) && (in_done || (diff_r > lag));
    last_out = (out_row_r == eff_h - HW'(1)) && (out_col_r == eff_w - WW'(1));
    wr_addr  = ADDR_W'(int'(in_ring_r) * MAX_WIDTH) + ADDR_W'(in_col_r);
    rd_addr  = ADDR_W'(int'(ring_r) * MAX_WIDTH) + ADDR_W'(col_r);
    div_try  = {div_rem_r, div_quo_r[SUM_W-1]};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    res.blurred   = div_quo_r[7:0];
    res.frame_end = frame_end_r;
    unique case (state_r)
      ecbb_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_pop  = 1'b1;
          state_nxt = ecbb_pkg::ST_STORE;
        end
      end
      ecbb_pkg::ST_STORE: state_nxt = ecbb_pkg::ST_CHECK;
      ecbb_pkg::ST_CHECK: state_nxt = ready ? ecbb_pkg::ST_SUM : ecbb_pkg::ST_IDLE;
      ecbb_pkg::ST_SUM: begin
        if (col_r == c1_r && rcnt_r == '0) begin
          state_nxt = ecbb_pkg::ST_FLUSH;
        end
      end
      ecbb_pkg::ST_FLUSH: state_nxt = ecbb_pkg::ST_DIV;
      ecbb_pkg::ST_DIV: begin
        if (div_n_r == DIVN_W'(1)) begin
          state_nxt = ecbb_pkg::ST_EMIT;
        end
      end
      ecbb_pkg::ST_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ecbb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ecbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecbb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // line store: write the incoming pixel, read one window tap per cycle
  always_ff @(posedge clk) begin
    if (state_r == ecbb_pkg::ST_STORE && item_r.kind == ecbb_pkg::KIND_PIXEL && !in_done) begin
      store_mem[wr_addr] <= item_r.pixel;
    end
    rd_q_r <= store_mem[rd_addr];
  end

  // payload path
  always_ff @(posedge clk) begin
    if (item_pop) begin
      item_r <= item;
    end
    if (rd_v_r) begin
      sum_r <= sum_r + SUM_W'(rd_q_r);
    end
    unique case (state_r)
      ecbb_pkg::ST_CHECK: begin
        ring_r      <= RING_W'(start_ring);
        rcnt_r      <= nrows - DIM_W'(1);
        col_r       <= out_col_r - WW'(left_n);
        c0_r        <= out_col_r - WW'(left_n);
        c1_r        <= out_col_r + WW'(right_n);
        cnt_r       <= CNT_W'(nrows) * CNT_W'(ncols);
        sum_r       <= '0;
        frame_end_r <= last_out;
      end
      ecbb_pkg::ST_SUM: begin
        if (col_r == c1_r) begin
          col_r  <= c0_r;
          rcnt_r <= rcnt_r - DIM_W'(1);
          ring_r <= (ring_r == RING_W'(RING - 1)) ? '0 : ring_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      ecbb_pkg::ST_FLUSH: begin
        div_quo_r <= sum_r + SUM_W'(rd_q_r);
        div_rem_r <= '0;
        div_n_r   <= DIVN_W'(SUM_W);
      end
      ecbb_pkg::ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (div_try >= (CNT_W + 1)'(cnt_r)) begin
          div_rem_r <= CNT_W'(div_try - (CNT_W + 1)'(cnt_r));
          div_quo_r <= {div_quo_r[SUM_W-2:0], 1'b1};
        end else begin
          div_rem_r <= CNT_W'(div_try);
          div_quo_r <= {div_quo_r[SUM_W-2:0], 1'b0};
        end
        div_n_r <= div_n_r - 1'b1;
      end
      default: ;
    endcase
  end

  // frame positions and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= ecbb_pkg::FWIDTH_W'(640);
      height_raw_r <= HW'(480);
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_ring_r <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      out_ring_r <= '0;
      diff_r    <= '0;
      rd_v_r    <= 1'b0;
    end else begin
      rd_v_r <= (state_r == ecbb_pkg::ST_SUM);
      if (cfg_we && (cfg_index == ecbb_pkg::CFG_IDX_WIDTH ||
                     cfg_index == ecbb_pkg::CFG_IDX_HEIGHT)) begin
        if (cfg_index == ecbb_pkg::CFG_IDX_WIDTH) begin
          width_raw_r <= cfg_data[ecbb_pkg::FWIDTH_W-1:0];
        end else begin
          height_raw_r <= cfg_data[HW-1:0];
        end
        // abort the frame in progress
        in_row_r <= '0;
        in_col_r <= '0;
        in_ring_r <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        out_ring_r <= '0;
        diff_r <= '0;
      end else if (state_r == ecbb_pkg::ST_STORE &&
                   item_r.kind == ecbb_pkg::KIND_PIXEL && !in_done) begin
        diff_r <= diff_r + 1'b1;
        if (in_col_r == eff_w - WW'(1)) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + 1'b1;
          in_ring_r <= (in_ring_r == RING_W'(RING - 1)) ? '0 : in_ring_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end else if (res_push) begin
        if (frame_end_r) begin
          in_row_r <= '0;
          in_col_r <= '0;
          in_ring_r <= '0;
          out_row_r <= '0;
          out_col_r <= '0;
          out_ring_r <= '0;
          diff_r <= '0;
        end else begin
          diff_r <= diff_r - 1'b1;
          if (out_col_r == eff_w - WW'(1)) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + 1'b1;
            out_ring_r <= (out_ring_r == RING_W'(RING - 1)) ? '0 : out_ring_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

### sim/tb_top.sv
// Self-checking testbench of the edge-clipped box blur filter.
`timescale 1ns / 100ps

module tb_top;

  localparam int RADIUS     = 10;
  localparam int MAX_WIDTH  = 1024;
  localparam int RING_ROWS  = 2 * RADIUS + 2;
  localparam int RAND_ITEMS = 700;
  // Worst item: a 21x21 window and up to two results queued ahead.
  localparam int DRAIN_WAIT = 1500;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;
  // Register indexes past the end of the list; writes to them are ignored.
  localparam logic [ecbb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [ecbb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  typedef struct {
    row_kind_t                          op;
    logic [ecbb_pkg::CFG_IDX_W-1:0]     idx;
    logic [ecbb_pkg::CFG_W-1:0]         data;
    logic [ecbb_pkg::KIND_W-1:0]        kind;
    logic [ecbb_pkg::PIXEL_W-1:0]       pixel;
    bit                                 typed;
    ecbb_pkg::result_t                  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ecbb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ecbb_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [ecbb_pkg::KIND_W-1:0] in_kind = ecbb_pkg::KIND_PIXEL;
  logic [ecbb_pkg::PIXEL_W-1:0] in_pixel = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [ecbb_pkg::PIXEL_W-1:0] out_blurred;
  logic out_frame_end;

  edge_clipped_box_blur #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_pixel     (in_pixel),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_blurred  (out_blurred),
    .out_frame_end(out_frame_end)
  );

  always #4 clk = ~clk;

  // Shadow copy of the filter: frame size, raster positions and the row ring.
  logic [ecbb_pkg::PIXEL_W-1:0] ring_rows [RING_ROWS*MAX_WIDTH];
  logic [ecbb_pkg::FWIDTH_W-1:0] shadow_width = 11'd640;
  logic [ecbb_pkg::HEIGHT_W-1:0] shadow_height = 13'd480;
  int unsigned pix_in_count = 0;
  int unsigned pix_out_count = 0;
  bit frame_closed;

  ecbb_pkg::result_t blur_expect_q[$];
  int mismatches = 0;
  longint cycle_count = 0;
  int rand_sent = 0;
  bit rand_phase = 0;
  int burst_left = 0;

  function automatic int unsigned active_width();
    if (shadow_width < 1) return 1;
    if (shadow_width > MAX_WIDTH) return MAX_WIDTH;
    return shadow_width;
  endfunction

  function automatic int unsigned active_height();
    if (shadow_height < 1) return 1;
    if (shadow_height > ecbb_pkg::MAX_HEIGHT) return ecbb_pkg::MAX_HEIGHT;
    return shadow_height;
  endfunction

  // Floor mean over the window clipped to the frame.
  function automatic logic [ecbb_pkg::PIXEL_W-1:0] clipped_mean(int unsigned pos,
                                                                int unsigned w,
                                                                int unsigned h);
    int unsigned row, col, r0, r1, c0, c1, acc, cnt;
    row = pos / w;
    col = pos % w;
    r0 = (row >= RADIUS) ? row - RADIUS : 0;
    r1 = (row + RADIUS < h) ? row + RADIUS : h - 1;
    c0 = (col >= RADIUS) ? col - RADIUS : 0;
    c1 = (col + RADIUS < w) ? col + RADIUS : w - 1;
    acc = 0;
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    for (int unsigned r = r0; r <= r1; r++) begin
      for (int unsigned c = c0; c <= c1; c++) begin
        acc += ring_rows[(r % RING_ROWS) * MAX_WIDTH + c];
      end
    end
    return ecbb_pkg::PIXEL_W'(acc / cnt);
  endfunction

  // Advance the shadow by one accepted transfer; return 1 when a result is due.
  function automatic bit blur_step(logic [ecbb_pkg::KIND_W-1:0] kind,
                                   logic [ecbb_pkg::PIXEL_W-1:0] pix,
                                   output ecbb_pkg::result_t res);
    int unsigned w, h, total, lag;
    w = active_width();
    h = active_height();
    total = w * h;
    lag = RADIUS * w + RADIUS;
    res = '0;
    if (kind == ecbb_pkg::KIND_PIXEL && pix_in_count < total) begin
      ring_rows[((pix_in_count / w) % RING_ROWS) * MAX_WIDTH + pix_in_count % w] = pix;
      pix_in_count++;
    end
    if (!(pix_out_count < total &&
          (pix_in_count == total || pix_in_count > pix_out_count + lag))) return 0;
    res.blurred = clipped_mean(pix_out_count, w, h);
    if (pix_out_count + 1 == total) begin
      res.frame_end = 1'b1;
      pix_in_count = 0;
      pix_out_count = 0;
      frame_closed = 1;
    end else begin
      pix_out_count++;
    end
    return 1;
  endfunction

  // Present one item, holding it until the transfer; bursts with random gaps.
  task automatic send_item(logic [ecbb_pkg::KIND_W-1:0] kind,
                           logic [ecbb_pkg::PIXEL_W-1:0] pix,
                           bit typed = 0, ecbb_pkg::result_t typed_res = '0);
    ecbb_pkg::result_t res;
    bit due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_push <= 1'b1;
    in_kind <= kind;
    in_pixel <= pix;
    do @(posedge clk); while (in_full);
    due = blur_step(kind, pix, res);
    if (due) blur_expect_q.push_back(typed ? typed_res : res);
    if (rand_phase) rand_sent++;
  endtask

  // Write one register once every expected result is out and the engine is quiet.
  task automatic write_reg(logic [ecbb_pkg::CFG_IDX_W-1:0] idx,
                           logic [ecbb_pkg::CFG_W-1:0] data);
    in_push <= 1'b0;
    burst_left = 0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ecbb_pkg::CFG_IDX_WIDTH) begin
      shadow_width = data[ecbb_pkg::FWIDTH_W-1:0];
    end else if (idx == ecbb_pkg::CFG_IDX_HEIGHT) begin
      shadow_height = data[ecbb_pkg::HEIGHT_W-1:0];
    end
    if (idx == ecbb_pkg::CFG_IDX_WIDTH || idx == ecbb_pkg::CFG_IDX_HEIGHT) begin
      pix_in_count = 0;
      pix_out_count = 0;
    end
  endtask

  // Feed npix pixels, with a few early drain ticks as noise; when finish is set,
  // drain (with some surplus pixels) until the frame closes.
  task automatic run_frame(int npix, bit finish);
    frame_closed = 0;
    for (int i = 0; i < npix && !frame_closed; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(ecbb_pkg::KIND_DRAIN, ecbb_pkg::PIXEL_W'($urandom));
      end
      send_item(ecbb_pkg::KIND_PIXEL, ecbb_pkg::PIXEL_W'($urandom));
    end
    while (finish && !frame_closed) begin
      send_item(($urandom_range(0, 9) == 0) ? ecbb_pkg::KIND_PIXEL : ecbb_pkg::KIND_DRAIN,
                ecbb_pkg::PIXEL_W'($urandom));
    end
  endtask

  // Receiver: check each transfer against the oldest expectation, then pick the
  // next pop level from a stall pattern that the receiver redraws as the run goes on.
  logic [15:0] stall_mask = 16'hffff;
  always @(posedge clk) begin
    ecbb_pkg::result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("edge_clipped_box_blur regression: fail");
      $finish;
    end
    if (rst_n && out_pop && !out_empty) begin
      if (blur_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: blurred=%0d frame_end=%0d", out_blurred,
                   out_frame_end);
        end
      end else begin
        want = blur_expect_q.pop_front();
        if (want.blurred !== out_blurred || want.frame_end !== out_frame_end) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected blurred=%0d frame_end=%0d, got %0d %0d",
                     want.blurred, want.frame_end, out_blurred, out_frame_end);
          end
        end
      end
    end
    if (cycle_count % 64 == 0) begin
      stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
    end
    out_pop <= stall_mask[cycle_count % 16];
  end

  stim_row_t directed[$];

  function automatic stim_row_t cfg_row(logic [ecbb_pkg::CFG_IDX_W-1:0] idx,
                                        logic [ecbb_pkg::CFG_W-1:0] data);
    stim_row_t r;
    r = '{ROW_CFG, idx, data, ecbb_pkg::KIND_PIXEL, '0, 0, '0};
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [ecbb_pkg::KIND_W-1:0] kind,
                                         logic [ecbb_pkg::PIXEL_W-1:0] pix,
                                         bit typed = 0,
                                         logic [ecbb_pkg::PIXEL_W-1:0] blur = '0,
                                         logic fend = 1'b0);
    stim_row_t r;
    r = '{ROW_ITEM, ecbb_pkg::CFG_IDX_WIDTH, '0, kind, pix, typed, '{blur, fend}};
    return r;
  endfunction

  initial begin
    int w, h, sel;
    // Default 640x480: lag is long, so these give nothing.
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd255));
    directed.push_back(item_row(ecbb_pkg::KIND_DRAIN, 8'd0));
    // One-pixel frame: every pixel comes straight back, closing the frame.
    directed.push_back(cfg_row(ecbb_pkg::CFG_IDX_WIDTH, 13'd1));
    directed.push_back(cfg_row(ecbb_pkg::CFG_IDX_HEIGHT, 13'd1));
    directed.push_back(item_row(ecbb_pkg::KIND_DRAIN, 8'd9));
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd0, 1, 8'd0, 1'b1));
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd255, 1, 8'd255, 1'b1));
    // Width zero saturates to one; index beyond the list is ignored.
    directed.push_back(cfg_row(ecbb_pkg::CFG_IDX_WIDTH, 13'h1800));
    directed.push_back(cfg_row(CFG_IDX_SPARE3, 13'h1fff));
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd7, 1, 8'd7, 1'b1));
    // 3x2 frame: all outputs wait for the whole frame, then drain out.
    directed.push_back(cfg_row(ecbb_pkg::CFG_IDX_WIDTH, 13'd3));
    directed.push_back(cfg_row(ecbb_pkg::CFG_IDX_HEIGHT, 13'd2));
    for (int i = 0; i < 6; i++) begin
      directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, (i % 2) ? 8'd0 : 8'd255));
    end
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd77));  // surplus pixel acts as drain
    for (int i = 0; i < 4; i++) directed.push_back(item_row(ecbb_pkg::KIND_DRAIN, 8'hff));
    // Height zero saturates to one.
    directed.push_back(cfg_row(ecbb_pkg::CFG_IDX_HEIGHT, 13'd0));
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd200));
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd100));
    directed.push_back(item_row(ecbb_pkg::KIND_PIXEL, 8'd1));
    for (int i = 0; i < 2; i++) directed.push_back(item_row(ecbb_pkg::KIND_DRAIN, 8'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].op == ROW_CFG) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_item(directed[i].kind, directed[i].pixel, directed[i].typed, directed[i].res);
      end
    end

    // Random frames: mostly small sizes, with the widest and tallest settings once.
    rand_phase = 1;
    sel = 0;
    while (rand_sent < RAND_ITEMS) begin
      sel++;
      if (sel == 3) begin
        write_reg(ecbb_pkg::CFG_IDX_WIDTH, 13'h07ff);   // saturates to the widest row
        write_reg(ecbb_pkg::CFG_IDX_HEIGHT, 13'd1);
        run_frame(60, 0);                               // abort part way through
      end else if (sel == 6) begin
        write_reg(ecbb_pkg::CFG_IDX_WIDTH, 13'd1);
        write_reg(ecbb_pkg::CFG_IDX_HEIGHT, 13'h1fff);  // saturates to the tallest frame
        run_frame(60, 0);                               // abort part way through
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          w = $urandom_range(1, 3);
          h = $urandom_range(1, 30);
        end else begin
          w = $urandom_range(1, 20);
          h = $urandom_range(1, 20);
        end
        if ($urandom_range(0, 5) == 0) write_reg(CFG_IDX_SPARE2, ecbb_pkg::CFG_W'($urandom));
        write_reg(ecbb_pkg::CFG_IDX_WIDTH, {2'($urandom), 11'(w)});
        write_reg(ecbb_pkg::CFG_IDX_HEIGHT, 13'(h));
        if ($urandom_range(0, 9) == 0) run_frame($urandom_range(1, w * h), 0);
        else run_frame(w * h, 1);
      end
    end

    in_push <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && blur_expect_q.size() == 0) begin
      $display("edge_clipped_box_blur regression: pass");
    end else begin
      $display("edge_clipped_box_blur regression: fail");
    end
    $finish;
  end

endmodule
